@@ src/dlmvb_pkg.sv @@
`default_nettype none

package dlmvb_pkg;

	localparam int MAX_ROWS    = 16;
	localparam int MAX_COLS    = 64;
	localparam int VALUE_BITS  = 16;
	localparam int FRAC_BITS   = 8;
	localparam int ROW_W       = 4;
	localparam int COL_W       = 6;
	localparam int ADDR_W      = ROW_W + COL_W;
	localparam int ACC_W       = 40;
	localparam int PROD_W      = 2 * VALUE_BITS;
	localparam int ROWS_CFG_W  = 5;
	localparam int COLS_CFG_W  = 7;
	localparam int CFG_W       = 7;
	localparam int CNT_W       = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [1:0] KIND_WEIGHT = 2'd0;
	localparam logic [1:0] KIND_BIAS   = 2'd1;
	localparam logic [1:0] KIND_ELEM   = 2'd2;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef struct packed {
		logic [1:0]                   kind;
		logic [ROW_W-1:0]             row_index;
		logic [COL_W-1:0]             col_index;
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
	} item_t;

	typedef struct packed {
		logic [ROW_W-1:0]             out_row;
		logic signed [VALUE_BITS-1:0] out_value;
		logic                         out_last;
		logic                         length_error;
	} result_t;

	typedef enum logic [1:0] {
		OP_WEIGHT,
		OP_BIAS,
		OP_ELEM
	} op_kind_t;

	typedef struct packed {
		op_kind_t                     op;
		logic [ROW_W-1:0]             row;
		logic [COL_W-1:0]             col;
		logic signed [VALUE_BITS-1:0] value;
		logic                         add;
		logic                         last;
		logic                         err;
	} op_t;

endpackage

`default_nettype wire

@@ src/dlmvb_front.sv @@
`default_nettype none

module dlmvb_front
	import dlmvb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire item_t                 item,
	input  wire logic                  full,
	input  wire logic [COLS_CFG_W-1:0] cols_eff,
	output logic                       push,
	output op_t                        push_op
);

	logic             accept;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_inc;
	logic             elem_acc;

	assign accept = start && !full;

	always_comb begin
		if (count_q < CNT_W'(MAX_COLS + 1)) begin
			count_inc = count_q + CNT_W'(1);
		end else begin
			count_inc = count_q;
		end
	end

	always_comb begin
		push_op.row   = item.row_index;
		push_op.col   = item.col_index;
		push_op.value = item.value;
		push_op.add   = 1'b0;
		push_op.last  = 1'b0;
		push_op.err   = 1'b0;
		push_op.op    = OP_ELEM;
		push          = 1'b0;
		elem_acc      = 1'b0;
		case (item.kind)
			KIND_WEIGHT: begin
				push_op.op = OP_WEIGHT;
				push       = accept;
			end
			KIND_BIAS: begin
				push_op.op = OP_BIAS;
				push       = accept;
			end
			KIND_ELEM: begin
				push_op.op   = OP_ELEM;
				push_op.add  = {1'b0, item.col_index} < cols_eff;
				push_op.last = item.last;
				push_op.err  = item.last && (count_inc != cols_eff);
				push         = accept;
				elem_acc     = accept;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (elem_acc) begin
			if (item.last) begin
				count_q <= '0;
			end else begin
				count_q <= count_inc;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/dlmvb_queue.sv @@
`default_nettype none

module dlmvb_queue
	import dlmvb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire op_t  push_op,
	input  wire logic pop,
	output op_t       head,
	output logic      empty,
	output logic      full
);

	op_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push || pop)
		else $error("word pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

`default_nettype wire

@@ src/dlmvb_back.sv @@
`default_nettype none

module dlmvb_back
	import dlmvb_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire op_t                   head,
	input  wire logic                  empty,
	input  wire logic [ROWS_CFG_W-1:0] rows_eff,
	output logic                       pop,
	output logic                       result_strobe,
	output result_t                    result
);

	localparam int REL_W = ACC_W + 2;
	localparam int Q_W   = REL_W - FRAC_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_OUT
	} state_t;

	state_t                       state_q;
	logic [ROW_W-1:0]             row_q;
	logic [COL_W-1:0]             col_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic                         last_q;
	logic                         err_q;
	result_t                      result_q;
	logic                         strobe_q;

	logic signed [VALUE_BITS-1:0] wmem [MAX_ROWS * MAX_COLS];
	logic signed [VALUE_BITS-1:0] bias_q [MAX_ROWS];
	logic signed [ACC_W-1:0]      acc_q [MAX_ROWS];

	logic                         v_s1;
	logic [ROW_W-1:0]             row_s1;
	logic signed [VALUE_BITS-1:0] rdata_s1;
	logic signed [VALUE_BITS-1:0] val_s1;
	logic                         v_s2;
	logic [ROW_W-1:0]             row_s2;
	logic signed [PROD_W-1:0]     prod_s2;

	logic                         issue;
	logic                         clear_acc;
	logic                         wr_weight;
	logic                         wr_bias;
	logic signed [ACC_W:0]        mac_sum;
	logic signed [ACC_W-1:0]      mac_sat;
	logic signed [ACC_W-1:0]      rel_acc;
	logic signed [VALUE_BITS-1:0] rel_bias;
	logic signed [REL_W-1:0]      rel_sum;
	logic [Q_W-1:0]               rel_q;
	logic signed [VALUE_BITS-1:0] rel_sat;
	logic                         row_final;

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign wr_weight = pop && (head.op == OP_WEIGHT);
	assign wr_bias   = pop && (head.op == OP_BIAS);
	assign issue     = (state_q == ST_MAC);
	assign row_final = ({1'b0, row_q} + ROWS_CFG_W'(1)) == rows_eff;
	assign clear_acc = (state_q == ST_OUT) && (err_q || row_final);

	assign result_strobe = strobe_q;
	assign result        = result_q;

	// weight store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_weight) begin
			wmem[{head.row, head.col}] <= head.value;
		end
		if (issue) begin
			rdata_s1 <= wmem[{row_q, col_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_bias) begin
			bias_q[head.row] <= head.value;
		end
	end

	// multiply and accumulate pipeline
	always_ff @(posedge clk) begin
		row_s1  <= row_q;
		val_s1  <= val_q;
		row_s2  <= row_s1;
		prod_s2 <= rdata_s1 * val_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		mac_sum = {acc_q[row_s2][ACC_W-1], acc_q[row_s2]}
			+ {{(ACC_W + 1 - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		if (mac_sum[ACC_W] != mac_sum[ACC_W-1]) begin
			mac_sat = mac_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
				: {1'b0, {(ACC_W - 1){1'b1}}};
		end else begin
			mac_sat = mac_sum[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_ROWS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (clear_acc) begin
			for (int i = 0; i < MAX_ROWS; i++) begin
				acc_q[i] <= '0;
			end
		end else if (v_s2) begin
			acc_q[row_s2] <= mac_sat;
		end
	end

	// release: add bias, round half up, saturate
	always_comb begin
		rel_acc  = acc_q[row_q];
		rel_bias = bias_q[row_q];
		rel_sum  = {{(REL_W - ACC_W){rel_acc[ACC_W-1]}}, rel_acc}
			+ {{(REL_W - VALUE_BITS - FRAC_BITS){rel_bias[VALUE_BITS-1]}}, rel_bias,
				{FRAC_BITS{1'b0}}}
			+ (REL_W'(1) << (FRAC_BITS - 1));
		rel_q    = rel_sum[REL_W-1:FRAC_BITS];
		if ((&rel_q[Q_W-1:VALUE_BITS-1]) || !(|rel_q[Q_W-1:VALUE_BITS-1])) begin
			rel_sat = rel_q[VALUE_BITS-1:0];
		end else if (rel_q[Q_W-1]) begin
			rel_sat = {1'b1, {(VALUE_BITS - 1){1'b0}}};
		end else begin
			rel_sat = {1'b0, {(VALUE_BITS - 1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			val_q    <= '0;
			last_q   <= 1'b0;
			err_q    <= 1'b0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= (state_q == ST_OUT);
			case (state_q)
				ST_IDLE: begin
					if (pop && (head.op == OP_ELEM)) begin
						col_q  <= head.col;
						val_q  <= head.value;
						last_q <= head.last;
						err_q  <= head.err;
						row_q  <= '0;
						if (head.add) begin
							state_q <= ST_MAC;
						end else if (head.last) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_MAC: begin
					row_q <= row_q + ROW_W'(1);
					if (row_q == ROW_W'(MAX_ROWS - 1)) begin
						state_q <= last_q ? ST_DRAIN : ST_IDLE;
					end
				end
				ST_DRAIN: begin
					row_q <= '0;
					if (!v_s1 && !v_s2) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (err_q) begin
						result_q.out_row      <= '0;
						result_q.out_value    <= '0;
						result_q.out_last     <= 1'b1;
						result_q.length_error <= 1'b1;
						state_q               <= ST_IDLE;
					end else begin
						result_q.out_row      <= row_q;
						result_q.out_value    <= rel_sat;
						result_q.out_last     <= row_final;
						result_q.length_error <= 1'b0;
						row_q                 <= row_q + ROW_W'(1);
						if (row_final) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_strobe_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == ST_OUT))
		else $error("result word without release state");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && result_q.length_error |-> result_q.out_last)
		else $error("length error word not marked last");

	a_out_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> !v_s1 && !v_s2)
		else $error("release while accumulation in flight");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !pop)
		else $error("queue read while back end busy");

endmodule

`default_nettype wire

@@ src/dense_layer_matvec_bias_unit.sv @@
`default_nettype none

// Dense layer column engine, y = W*x + b in signed Q8.8. Each word on item is
// taken when start is high and busy is low; busy rises only when the two-entry
// queue between the front end and the back end is full. Weight and bias writes
// are done in the back end as they leave the queue. An input element leaves the
// queue and then runs through all 16 weight rows in turn in the single shared
// multiply-accumulate unit, or skips that unit when its position is beyond the
// column count. After the element marked last, that unit drains, then there is
// one result word per row in use on consecutive cycles (one word on a length
// error), each appearing the cycle after its row is released. Result words
// are shown for exactly one cycle with result_strobe and cannot be held off.
// Configuration is to be written only while the block is idle.

module dense_layer_matvec_bias_unit
	import dlmvb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire item_t            item,
	output logic                  busy,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output logic                  result_strobe,
	output result_t               result
);

	logic [ROWS_CFG_W-1:0] rows_q;
	logic [COLS_CFG_W-1:0] cols_q;
	logic [ROWS_CFG_W-1:0] rows_eff;
	logic [COLS_CFG_W-1:0] cols_eff;

	logic push;
	op_t  push_op;
	logic pop;
	op_t  head;
	logic empty;
	logic full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_CFG_W'(MAX_ROWS);
			cols_q <= COLS_CFG_W'(MAX_COLS);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS: rows_q <= cfg_data[ROWS_CFG_W-1:0];
				CFG_COLS: cols_q <= cfg_data[COLS_CFG_W-1:0];
				default: begin
					rows_q <= rows_q;
				end
			endcase
		end
	end

	always_comb begin
		if (rows_q == '0) begin
			rows_eff = ROWS_CFG_W'(1);
		end else if (rows_q > ROWS_CFG_W'(MAX_ROWS)) begin
			rows_eff = ROWS_CFG_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_q;
		end
		if (cols_q == '0) begin
			cols_eff = COLS_CFG_W'(1);
		end else if (cols_q > COLS_CFG_W'(MAX_COLS)) begin
			cols_eff = COLS_CFG_W'(MAX_COLS);
		end else begin
			cols_eff = cols_q;
		end
	end

	assign busy = full;

	dlmvb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.item     (item),
		.full     (full),
		.cols_eff (cols_eff),
		.push     (push),
		.push_op  (push_op)
	);

	dlmvb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head    (head),
		.empty   (empty),
		.full    (full)
	);

	dlmvb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.rows_eff      (rows_eff),
		.pop           (pop),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

`default_nettype wire

@@ sim/dense_layer_matvec_bias_unit_tb.sv @@
`timescale 1ns / 1ps

module dense_layer_matvec_bias_unit_tb;
	import dlmvb_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 64;
	localparam int REPORT_LIMIT = 10;
	localparam int LOADED_COLS = 2;
	localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -ACC_HI - 1;
	localparam longint OUT_HI = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
	localparam longint OUT_LO = -OUT_HI - 1;
	localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 16'sh7fff;
	localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 16'sh8000;

	logic clk;
	logic arst_n;
	logic start;
	item_t item;
	logic busy;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic result_strobe;
	result_t result;

	logic signed [VALUE_BITS-1:0] weight_mem [MAX_ROWS*MAX_COLS];
	logic signed [VALUE_BITS-1:0] bias_mem [MAX_ROWS];
	longint row_acc [MAX_ROWS];
	int unsigned elems_seen;
	logic [ROWS_CFG_W-1:0] rows_reg;
	logic [COLS_CFG_W-1:0] cols_reg;
	result_t pending_outputs [$];
	result_t oldest;

	int unsigned words_accepted;
	int unsigned results_seen;
	int unsigned length_errors_seen;
	int unsigned reg_writes;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	bit steady;

	dense_layer_matvec_bias_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_strobe(result_strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_rows();
		if (rows_reg == 0) return 1;
		if (rows_reg > MAX_ROWS) return MAX_ROWS;
		return int'(rows_reg);
	endfunction

	function automatic int eff_cols();
		if (cols_reg == 0) return 1;
		if (cols_reg > MAX_COLS) return MAX_COLS;
		return int'(cols_reg);
	endfunction

	// positions that would read an unloaded weight column fold onto loaded ones
	function automatic int safe_col(input int c);
		if (c >= LOADED_COLS && c < eff_cols()) return c % LOADED_COLS;
		return c;
	endfunction

	task automatic layer_step(input item_t w);
		int nrows;
		int ncols;
		longint sum;
		result_t r;
		nrows = eff_rows();
		ncols = eff_cols();
		case (w.kind)
		KIND_WEIGHT: weight_mem[{w.row_index, w.col_index}] = w.value;
		KIND_BIAS: bias_mem[w.row_index] = w.value;
		KIND_ELEM: begin
			if (w.col_index < ncols) begin
				for (int i = 0; i < MAX_ROWS; i++) begin
					sum = row_acc[i] + longint'(weight_mem[i * MAX_COLS + w.col_index])
						* longint'($signed(w.value));
					row_acc[i] = (sum > ACC_HI) ? ACC_HI : ((sum < ACC_LO) ? ACC_LO : sum);
				end
			end
			if (elems_seen < MAX_COLS + 1) elems_seen++;
			if (w.last) begin
				if (elems_seen == ncols) begin
					for (int i = 0; i < nrows; i++) begin
						sum = (row_acc[i] + longint'(bias_mem[i]) * 256 + 128) >>> FRAC_BITS;
						if (sum > OUT_HI) sum = OUT_HI;
						if (sum < OUT_LO) sum = OUT_LO;
						r.out_row = ROW_W'(i);
						r.out_value = sum[VALUE_BITS-1:0];
						r.out_last = (i == nrows - 1);
						r.length_error = 1'b0;
						pending_outputs.push_back(r);
					end
				end else begin
					r = '0;
					r.out_last = 1'b1;
					r.length_error = 1'b1;
					pending_outputs.push_back(r);
				end
				row_acc = '{default: 0};
				elems_seen = 0;
			end
		end
		default: ;
		endcase
	endtask

	function automatic item_t make_word(input logic [1:0] kind, input int row, input int col,
			input logic signed [VALUE_BITS-1:0] value, input bit last);
		item_t w;
		w.kind = kind;
		w.row_index = ROW_W'(row);
		w.col_index = COL_W'(col);
		w.value = value;
		w.last = last;
		return w;
	endfunction

	function automatic logic signed [VALUE_BITS-1:0] pick_value(input bit wild);
		int v;
		case (wild ? $urandom_range(9) : 9)
		0: v = -32768;
		1: v = 32767;
		2: v = $urandom;
		default: v = int'($urandom_range(512)) - 256;
		endcase
		return v[VALUE_BITS-1:0];
	endfunction

	task automatic send_word(input item_t w);
		while (!steady && $urandom_range(99) < 12) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		layer_step(w);
		words_accepted++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == CFG_ROWS) rows_reg = data[ROWS_CFG_W-1:0];
		else cols_reg = data[COLS_CFG_W-1:0];
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_shape(input logic [CFG_W-1:0] rows_data, input logic [CFG_W-1:0] cols_data);
		wait_drained();
		write_reg(CFG_ROWS, rows_data);
		write_reg(CFG_COLS, cols_data);
	endtask

	task automatic send_store_write();
		send_word(make_word($urandom_range(1) ? KIND_WEIGHT : KIND_BIAS,
			$urandom_range(MAX_ROWS - 1), $urandom_range(MAX_COLS - 1), pick_value(1), $urandom_range(1)));
	endtask

	task automatic send_vector(input int n, input bit scatter, input bit with_writes);
		int c;
		for (int i = 0; i < n; i++) begin
			if (with_writes && $urandom_range(4) == 0) send_store_write();
			c = safe_col((scatter && $urandom_range(3) == 0) ? $urandom_range(MAX_COLS - 1) : i);
			send_word(make_word(KIND_ELEM, $urandom_range(MAX_ROWS - 1), c, pick_value(1), i == n - 1));
		end
	endtask

	task automatic test_preload_stores();
		// every bias, and weights for the columns that elements read
		for (int r = 0; r < MAX_ROWS; r++) begin
			send_word(make_word(KIND_BIAS, r, 0, pick_value(0), 1'b0));
			for (int c = 0; c < LOADED_COLS; c++)
				send_word(make_word(KIND_WEIGHT, r, c, pick_value(0), 1'b0));
		end
	endtask

	task automatic test_directed_corners();
		set_shape(7'd16, 7'd2);
		send_word(make_word(KIND_WEIGHT, 0, 0, VAL_MIN, 1'b0));
		send_word(make_word(KIND_WEIGHT, 0, 1, VAL_MIN, 1'b0));
		send_word(make_word(KIND_WEIGHT, 1, 0, VAL_MAX, 1'b0));
		send_word(make_word(KIND_WEIGHT, 1, 1, VAL_MIN, 1'b0));
		send_word(make_word(KIND_WEIGHT, 2, 1, VAL_MAX, 1'b0));
		send_word(make_word(KIND_WEIGHT, 15, 63, VAL_MAX, 1'b1));
		send_word(make_word(KIND_BIAS, 0, 0, VAL_MAX, 1'b0));
		send_word(make_word(KIND_BIAS, 1, 0, VAL_MIN, 1'b0));
		send_word(make_word(KIND_BIAS, 15, 63, VAL_MIN, 1'b0));
		// saturation both ways
		send_word(make_word(KIND_ELEM, 0, 0, VAL_MIN, 1'b0));
		send_word(make_word(KIND_ELEM, 0, 1, VAL_MIN, 1'b1));
		send_word(make_word(KIND_UNUSED, 15, 63, VAL_MAX, 1'b1));
		// positions past the column count are counted only
		send_word(make_word(KIND_ELEM, 15, 63, VAL_MAX, 1'b0));
		send_word(make_word(KIND_ELEM, 0, 0, 16'sh0001, 1'b1));
		send_word(make_word(KIND_ELEM, 0, 1, VAL_MAX, 1'b1));
		send_word(make_word(KIND_ELEM, 0, 0, 16'sh0100, 1'b0));
		send_word(make_word(KIND_ELEM, 0, 1, 16'sh0100, 1'b0));
		send_word(make_word(KIND_ELEM, 0, 2, 16'sh0100, 1'b0));
		send_word(make_word(KIND_ELEM, 0, 0, 16'sh0100, 1'b1));
	endtask

	task automatic run_shape(input logic [CFG_W-1:0] rows_data, input logic [CFG_W-1:0] cols_data);
		set_shape(rows_data, cols_data);
		send_vector(eff_cols(), 0, 0);
		send_vector($urandom_range(1, 2), 1, 0);
	endtask

	task automatic test_register_extremes();
		run_shape(7'h00, 7'h00);
		steady = 1;
		run_shape(7'h7f, 7'h7f);
		steady = 0;
		run_shape(7'h01, 7'h01);
		run_shape(7'h60, 7'h03);
		run_shape(7'h1f, 7'h02);
	endtask

	task automatic test_random_traffic();
		int unsigned phase_base;
		for (int phase = 0; phase < 3; phase++) begin
			set_shape(CFG_W'($urandom), CFG_W'($urandom_range(1, 6)));
			steady = (phase == 1);
			phase_base = words_accepted;
			while (words_accepted - phase_base < 10) begin
				case ($urandom_range(19))
				0, 1: send_store_write();
				2: send_vector(eff_cols() + 1, 1, 0);
				3: send_vector($urandom_range(1, eff_cols()), 1, 1);
				4: begin
					send_word(make_word(KIND_UNUSED, $urandom_range(MAX_ROWS - 1),
						$urandom_range(MAX_COLS - 1), pick_value(1), $urandom_range(1)));
					phase_base++;
				end
				5: wait_drained();
				default: send_vector(eff_cols(), $urandom_range(3) == 0, $urandom_range(4) == 0);
				endcase
			end
		end
		steady = 0;
	endtask

	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			results_seen++;
			if (result.length_error) length_errors_seen++;
			if (pending_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected result word: row %0d value %0d last %b err %b", $time,
						result.out_row, result.out_value, result.out_last, result.length_error);
			end else begin
				oldest = pending_outputs.pop_front();
				if (result.out_row !== oldest.out_row || result.out_value !== oldest.out_value
						|| result.out_last !== oldest.out_last
						|| result.length_error !== oldest.length_error) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: expected row %0d value %0d last %b err %b, got row %0d value %0d last %b err %b",
							$time, oldest.out_row, oldest.out_value, oldest.out_last,
							oldest.length_error, result.out_row, result.out_value,
							result.out_last, result.length_error);
				end
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || result_strobe || cfg_we) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("timeout: nothing moved for %0d cycles", QUIET_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = '0;
		steady = 0;
		rows_reg = ROWS_CFG_W'(MAX_ROWS);
		cols_reg = COLS_CFG_W'(MAX_COLS);
		row_acc = '{default: 0};
		elems_seen = 0;
		words_accepted = 0;
		results_seen = 0;
		length_errors_seen = 0;
		reg_writes = 0;
		mismatches = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_preload_stores();
		test_directed_corners();
		test_register_extremes();
		test_random_traffic();
		wait_drained();
		$display("sent %0d input words with %0d register writes across several shapes",
			words_accepted, reg_writes);
		$display("checked %0d result words, %0d of them length errors, %0d mismatches",
			results_seen, length_errors_seen, mismatches);
		if (mismatches == 0 && pending_outputs.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ dense_layer_matvec_bias_unit.f @@
src/dlmvb_pkg.sv
src/dlmvb_front.sv
src/dlmvb_queue.sv
src/dlmvb_back.sv
src/dense_layer_matvec_bias_unit.sv
sim/dense_layer_matvec_bias_unit_tb.sv
